>>> rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Field widths, microcode word layout and the page count rounding helper.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int TOTAL_PAGES_DEF = 1024;

  localparam int PC_W   = 11;  // page_count field
  localparam int OFF_W  = 10;  // block_offset / alloc_offset fields
  localparam int PF_W   = 11;  // pages_free field
  localparam int N_W    = 12;  // rounded page count, up to 2048
  localparam int STEP_W = 5;   // microcode step address

  localparam logic OP_FREE = 1'b1;

  // node index update
  typedef enum logic [2:0] {
    H_HOLD,
    H_ZERO,
    H_ROOT,
    H_CHILD,
    H_PARENT,
    H_LEAF,
    H_INC
  } h_sel_e;

  // block size update
  typedef enum logic [2:0] {
    SZ_HOLD,
    SZ_SPAN,
    SZ_HALF,
    SZ_DOUBLE,
    SZ_ONE
  } sz_sel_e;

  // tree write
  typedef enum logic [2:0] {
    WR_NONE,
    WR_ZERO,
    WR_SIZE,
    WR_MAX,
    WR_MERGE,
    WR_INIT
  } wr_sel_e;

  // free counter update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_SUB,
    CNT_ADD
  } cnt_sel_e;

  // branch conditions
  typedef enum logic [3:0] {
    CND_ALWAYS,
    CND_NOACC,
    CND_OPFREE,
    CND_NOFIT,
    CND_SZ_LE_N,
    CND_HALF_LE_N,
    CND_SZ_GE_N,
    CND_DBL_GE_N,
    CND_H_ROOT,
    CND_FREE_BAD,
    CND_OUT_BUSY,
    CND_CLR_LAST
  } cond_e;

  typedef struct packed {
    logic                take;
    h_sel_e              h_sel;
    sz_sel_e             sz_sel;
    wr_sel_e             wr_sel;
    cnt_sel_e            cnt_sel;
    logic                set_fail;
    logic                load_out;
    cond_e               cond;
    logic [STEP_W-1:0]   t_next;
    logic [STEP_W-1:0]   f_next;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic noacc;
    logic opfree;
    logic nofit;
    logic sz_le_n;
    logic half_le_n;
    logic sz_ge_n;
    logic dbl_ge_n;
    logic h_root;
    logic free_bad;
    logic out_busy;
    logic clr_last;
  } cond_t;

  // smallest power of two not below x, zero counts as one
  function automatic logic [N_W-1:0] pow2_ceil(input logic [PC_W-1:0] x);
    logic [N_W-1:0] m;
    m = N_W'(x) - N_W'(1);
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    if (x == '0) begin
      return N_W'(1);
    end
    return m + N_W'(1);
  endfunction

endpackage

>>> rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bpa_seq.sv
// ----------------------------------------------------------------------------
// Buddy allocator sequencer
// Microcode ROM, step counter and two-way conditional branch.
// ----------------------------------------------------------------------------
module bpa_seq
  import bpa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cond_t cond_i,
  output ctrl_t ctrl_o
);

  localparam logic [STEP_W-1:0] S_CLR    = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_IDLE   = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_DISP   = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_ACHK   = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_ATST   = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_ADESC  = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_AMARK  = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_AUP    = STEP_W'(7);
  localparam logic [STEP_W-1:0] S_CSUB   = STEP_W'(8);
  localparam logic [STEP_W-1:0] S_AFAIL  = STEP_W'(9);
  localparam logic [STEP_W-1:0] S_FCHK   = STEP_W'(10);
  localparam logic [STEP_W-1:0] S_FTST   = STEP_W'(11);
  localparam logic [STEP_W-1:0] S_FCLIMB = STEP_W'(12);
  localparam logic [STEP_W-1:0] S_FMARK  = STEP_W'(13);
  localparam logic [STEP_W-1:0] S_FUP    = STEP_W'(14);
  localparam logic [STEP_W-1:0] S_CADD   = STEP_W'(15);
  localparam logic [STEP_W-1:0] S_OUT    = STEP_W'(16);

  function automatic ctrl_t rom(input logic [STEP_W-1:0] s);
    ctrl_t w;
    w = '0;
    case (s)
      S_CLR: begin
        w.h_sel = H_INC;   w.wr_sel = WR_INIT;
        w.cond = CND_CLR_LAST; w.t_next = S_IDLE; w.f_next = S_CLR;
      end
      S_IDLE: begin
        w.take = 1'b1;     w.h_sel = H_ZERO;
        w.cond = CND_NOACC; w.t_next = S_IDLE; w.f_next = S_DISP;
      end
      S_DISP: begin
        w.cond = CND_OPFREE; w.t_next = S_FCHK; w.f_next = S_ACHK;
      end
      S_ACHK: begin
        w.h_sel = H_ROOT;  w.sz_sel = SZ_SPAN;
        w.cond = CND_NOFIT; w.t_next = S_AFAIL; w.f_next = S_ATST;
      end
      S_ATST: begin
        w.cond = CND_SZ_LE_N; w.t_next = S_AMARK; w.f_next = S_ADESC;
      end
      S_ADESC: begin
        w.h_sel = H_CHILD; w.sz_sel = SZ_HALF;
        w.cond = CND_HALF_LE_N; w.t_next = S_AMARK; w.f_next = S_ADESC;
      end
      S_AMARK: begin
        w.h_sel = H_PARENT; w.wr_sel = WR_ZERO;
        w.cond = CND_H_ROOT; w.t_next = S_CSUB; w.f_next = S_AUP;
      end
      S_AUP: begin
        w.h_sel = H_PARENT; w.wr_sel = WR_MAX;
        w.cond = CND_H_ROOT; w.t_next = S_CSUB; w.f_next = S_AUP;
      end
      S_CSUB: begin
        w.cnt_sel = CNT_SUB;
        w.cond = CND_ALWAYS; w.t_next = S_OUT; w.f_next = S_OUT;
      end
      S_AFAIL: begin
        w.set_fail = 1'b1;
        w.cond = CND_ALWAYS; w.t_next = S_OUT; w.f_next = S_OUT;
      end
      S_FCHK: begin
        w.h_sel = H_LEAF;  w.sz_sel = SZ_ONE;
        w.cond = CND_FREE_BAD; w.t_next = S_OUT; w.f_next = S_FTST;
      end
      S_FTST: begin
        w.cond = CND_SZ_GE_N; w.t_next = S_FMARK; w.f_next = S_FCLIMB;
      end
      S_FCLIMB: begin
        w.h_sel = H_PARENT; w.sz_sel = SZ_DOUBLE;
        w.cond = CND_DBL_GE_N; w.t_next = S_FMARK; w.f_next = S_FCLIMB;
      end
      S_FMARK: begin
        w.h_sel = H_PARENT; w.sz_sel = SZ_DOUBLE; w.wr_sel = WR_SIZE;
        w.cond = CND_H_ROOT; w.t_next = S_CADD; w.f_next = S_FUP;
      end
      S_FUP: begin
        w.h_sel = H_PARENT; w.sz_sel = SZ_DOUBLE; w.wr_sel = WR_MERGE;
        w.cond = CND_H_ROOT; w.t_next = S_CADD; w.f_next = S_FUP;
      end
      S_CADD: begin
        w.cnt_sel = CNT_ADD;
        w.cond = CND_ALWAYS; w.t_next = S_OUT; w.f_next = S_OUT;
      end
      S_OUT: begin
        w.load_out = 1'b1; w.h_sel = H_ZERO;
        w.cond = CND_OUT_BUSY; w.t_next = S_OUT; w.f_next = S_IDLE;
      end
      default: begin
        w.cond = CND_ALWAYS; w.t_next = S_IDLE; w.f_next = S_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] upc_q, upc_d;
  ctrl_t             w;
  logic              taken;

  assign w = rom(upc_q);

  always_comb begin
    case (w.cond)
      CND_ALWAYS:    taken = 1'b1;
      CND_NOACC:     taken = cond_i.noacc;
      CND_OPFREE:    taken = cond_i.opfree;
      CND_NOFIT:     taken = cond_i.nofit;
      CND_SZ_LE_N:   taken = cond_i.sz_le_n;
      CND_HALF_LE_N: taken = cond_i.half_le_n;
      CND_SZ_GE_N:   taken = cond_i.sz_ge_n;
      CND_DBL_GE_N:  taken = cond_i.dbl_ge_n;
      CND_H_ROOT:    taken = cond_i.h_root;
      CND_FREE_BAD:  taken = cond_i.free_bad;
      CND_OUT_BUSY:  taken = cond_i.out_busy;
      CND_CLR_LAST:  taken = cond_i.clr_last;
      default:       taken = 1'b1;
    endcase
    upc_d = taken ? w.t_next : w.f_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = w;

endmodule

>>> rtl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Binary buddy tree of longest free runs, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+----------------------------
//  in      | to block  | in_valid_i / in_stall_o   | op, page_count, block_offset
//  out     | from block| out_valid_o / out_stall_i | status, alloc_offset,
//          |           |                           | pages_free
//
//  One word at a time. The tree walk goes one tree level per cycle down and
//  up, with one read and one write of the tree RAMs per cycle.
//  After reset a clearing pass writes SPAN rows with in_stall_o high. A
//  finished result waits in the output register while the next word is
//  accepted; the sequencer waits only if a second result is ready before
//  the first one is taken.
// ----------------------------------------------------------------------------
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int TOTAL_PAGES = TOTAL_PAGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [PC_W-1:0]  page_count_i,
  input  logic [OFF_W-1:0] block_offset_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             status_o,
  output logic [OFF_W-1:0] alloc_offset_o,
  output logic [PF_W-1:0]  pages_free_o
);

  // SPAN: managed area, TOTAL_PAGES rounded up to a power of two.
  // Nodes use heap numbering: root 1, children 2h and 2h+1.
  // Even nodes live in the left RAM, odd nodes in the right RAM, both at row
  // h>>1, so one row read returns both children of node h.
  localparam int LOG_SPAN = $clog2(TOTAL_PAGES);
  localparam int SPAN     = 1 << LOG_SPAN;
  localparam int RW       = LOG_SPAN;          // RAM row
  localparam int AW       = LOG_SPAN + 1;      // heap node index
  localparam int VW       = LOG_SPAN + 1;      // node value 0..SPAN
  localparam int CW       = ((VW > N_W) ? VW : N_W) + 1;  // compare width

  localparam logic [VW-1:0] SPAN_V  = VW'(SPAN);
  localparam logic [VW-1:0] TOTAL_V = VW'(TOTAL_PAGES);

  ctrl_t ctrl;
  cond_t cond;

  logic accept;

  // request
  logic             op_q;
  logic [CW-1:0]    n_q;
  logic [OFF_W-1:0] off_q;

  // walk state
  logic [AW-1:0] h_q, h_d;
  logic [VW-1:0] sz_q, sz_d;
  logic [RW-1:0] acc_q, acc_d;
  logic [VW-1:0] fv_q;        // init value during clearing pass
  logic [VW-1:0] cnt_q, cnt_d;
  logic          fail_q;

  // tree RAM ports
  logic          we_l, we_r;
  logic [RW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [RW-1:0] raddr;
  logic [VW-1:0] ram_l, ram_r;
  logic [VW-1:0] rd_l, rd_r;

  // write bypass: last cycle's node write vs. the row now being returned
  logic          pw_en_q;
  logic [AW-1:0] pw_node_q;
  logic [VW-1:0] pw_val_q;
  logic [RW-1:0] pr_row_q;
  logic          byp;

  logic          node_wr;
  logic          go_left;
  logic [VW-1:0] mx;
  logic [VW:0]   lr_sum;
  logic [VW:0]   cnt_sum;
  logic [RW-1:0] clr_row;

  // output register
  logic             out_valid_q;
  logic             status_q;
  logic [OFF_W-1:0] alloc_off_q;
  logic [PF_W-1:0]  pages_free_q;
  logic             out_busy;

  bpa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  assign in_stall_o = !ctrl.take;
  assign accept     = in_valid_i && ctrl.take;
  assign out_busy   = out_valid_q && out_stall_i;

  // children of h_q as of the read issued last cycle, with bypass
  assign byp  = pw_en_q && (pw_node_q[AW-1:1] == pr_row_q);
  assign rd_l = (byp && !pw_node_q[0]) ? pw_val_q : ram_l;
  assign rd_r = (byp &&  pw_node_q[0]) ? pw_val_q : ram_r;

  assign mx      = (rd_l > rd_r) ? rd_l : rd_r;
  assign lr_sum  = {1'b0, rd_l} + {1'b0, rd_r};
  assign go_left = CW'(rd_l) >= n_q;
  assign clr_row = h_q[RW-1:0];

  // branch flags
  always_comb begin
    cond.noacc     = !in_valid_i;
    cond.opfree    = (op_q == OP_FREE);
    // at the check step rd_r holds the root
    cond.nofit     = (n_q > CW'(cnt_q)) || (CW'(rd_r) < n_q);
    cond.sz_le_n   = CW'(sz_q) <= n_q;
    cond.half_le_n = CW'(sz_q >> 1) <= n_q;
    cond.sz_ge_n   = CW'(sz_q) >= n_q;
    cond.dbl_ge_n  = CW'({sz_q, 1'b0}) >= n_q;
    cond.h_root    = (h_q == AW'(1));
    cond.free_bad  = (n_q > CW'(SPAN_V)) || (32'(off_q) >= 32'(SPAN));
    cond.out_busy  = out_busy;
    cond.clr_last  = (clr_row == {RW{1'b1}});
  end

  // datapath next values
  always_comb begin
    case (ctrl.h_sel)
      H_HOLD:   h_d = h_q;
      H_ZERO:   h_d = '0;
      H_ROOT:   h_d = AW'(1);
      H_CHILD:  h_d = {h_q[AW-2:0], !go_left};
      H_PARENT: h_d = h_q >> 1;
      H_LEAF:   h_d = AW'(32'(SPAN) + 32'(off_q));
      H_INC:    h_d = h_q + AW'(1);
      default:  h_d = h_q;
    endcase

    case (ctrl.sz_sel)
      SZ_HOLD:   sz_d = sz_q;
      SZ_SPAN:   sz_d = SPAN_V;
      SZ_HALF:   sz_d = sz_q >> 1;
      SZ_DOUBLE: sz_d = {sz_q[VW-2:0], 1'b0};
      SZ_ONE:    sz_d = VW'(1);
      default:   sz_d = sz_q;
    endcase

    // going right adds the child's size to the block offset
    acc_d = acc_q;
    if (ctrl.h_sel == H_CHILD && !go_left) begin
      acc_d = acc_q + RW'(sz_q >> 1);
    end

    cnt_sum = {1'b0, cnt_q} + {1'b0, VW'(n_q)};
    case (ctrl.cnt_sel)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_SUB:  cnt_d = cnt_q - VW'(n_q);
      CNT_ADD:  cnt_d = (cnt_sum > {1'b0, TOTAL_V}) ? TOTAL_V : cnt_sum[VW-1:0];
      default:  cnt_d = cnt_q;
    endcase
  end

  // tree write
  always_comb begin
    node_wr = 1'b0;
    wdata   = '0;
    case (ctrl.wr_sel)
      WR_NONE:  wdata = '0;
      WR_ZERO: begin
        node_wr = 1'b1;
        wdata   = '0;
      end
      WR_SIZE: begin
        node_wr = 1'b1;
        wdata   = sz_q;
      end
      WR_MAX: begin
        node_wr = 1'b1;
        wdata   = mx;
      end
      WR_MERGE: begin
        // both halves wholly free: node becomes whole again
        node_wr = 1'b1;
        wdata   = (lr_sum == {1'b0, sz_q}) ? sz_q : mx;
      end
      WR_INIT:  wdata = fv_q;
      default:  wdata = '0;
    endcase

    if (ctrl.wr_sel == WR_INIT) begin
      we_l  = 1'b1;
      we_r  = 1'b1;
      waddr = clr_row;
    end else begin
      we_l  = node_wr && !h_q[0];
      we_r  = node_wr &&  h_q[0];
      waddr = h_q[AW-1:1];
    end
  end

  // read the children of the next node
  assign raddr = h_d[RW-1:0];

  bpa_ram #(
    .WIDTH (VW),
    .DEPTH (SPAN)
  ) u_ram_l (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_l)
  );

  bpa_ram #(
    .WIDTH (VW),
    .DEPTH (SPAN)
  ) u_ram_r (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_r)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q         <= '0;
      fv_q        <= SPAN_V;
      cnt_q       <= TOTAL_V;
      pw_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      h_q     <= h_d;
      cnt_q   <= cnt_d;
      pw_en_q <= node_wr;
      // clearing pass: value halves at each new tree level
      if (ctrl.wr_sel == WR_INIT && (((clr_row + RW'(1)) & clr_row) == '0)) begin
        fv_q <= fv_q >> 1;
      end
      if (ctrl.load_out && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    sz_q      <= sz_d;
    pw_node_q <= h_q;
    pw_val_q  <= wdata;
    pr_row_q  <= raddr;
    if (accept) begin
      op_q   <= op_i;
      n_q    <= CW'(pow2_ceil(page_count_i));
      off_q  <= block_offset_i;
      acc_q  <= '0;
      fail_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (ctrl.set_fail) begin
        fail_q <= 1'b1;
      end
    end
    if (ctrl.load_out && !out_busy) begin
      status_q     <= fail_q;
      alloc_off_q  <= OFF_W'(acc_q);
      pages_free_q <= PF_W'(cnt_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign alloc_offset_o = alloc_off_q;
  assign pages_free_o   = pages_free_q;

endmodule

>>> tb/bpa_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator checker
// Watches both channels and keeps its own copy of the buddy tree and the free
// page counter. It predicts the result word of every accepted request and
// compares each result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bpa_alloc_checker
  import bpa_pkg::*;
#(
  parameter int TOTAL_PAGES = TOTAL_PAGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             op_i,
  input  logic [PC_W-1:0]  page_count_i,
  input  logic [OFF_W-1:0] block_offset_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             status_i,
  input  logic [OFF_W-1:0] alloc_offset_i,
  input  logic [PF_W-1:0]  pages_free_i,
  output int               mismatches_o,
  output int               pending_o
);

  localparam int SPAN  = 1 << $clog2(TOTAL_PAGES);
  localparam int NODES = 2 * SPAN - 1;

  typedef struct packed {
    logic             status;
    logic [OFF_W-1:0] alloc_offset;
    logic [PF_W-1:0]  pages_free;
  } result_word_t;

  logic [N_W-1:0] longest_run [NODES];
  int unsigned    pages_left;
  int             error_total;
  result_word_t   awaited_words [$];

  // request size rounded up to a power of two, zero counts as one
  function automatic int unsigned block_size(input logic [PC_W-1:0] cnt);
    int unsigned sz;
    sz = 1;
    while (sz < cnt) sz = sz << 1;
    return sz;
  endfunction

  // every node starts out holding the size of its whole subtree
  task automatic clear_tree();
    int unsigned sz;
    int          i;
    sz = 2 * SPAN;
    for (i = 0; i < NODES; i++) begin
      if (((i + 1) & i) == 0) sz = sz >> 1;
      longest_run[i] = N_W'(sz);
    end
    pages_left = TOTAL_PAGES;
  endtask

  // applies one request to the tree copy and returns the word it yields
  function automatic result_word_t apply_request(input logic             op,
                                                 input logic [PC_W-1:0]  cnt,
                                                 input logic [OFF_W-1:0] offs);
    result_word_t res;
    int unsigned  need;
    int unsigned  node;
    int unsigned  sz;
    int unsigned  lft;
    int unsigned  rgt;
    res  = '0;
    need = block_size(cnt);
    if (op != OP_FREE) begin
      if (need > pages_left || longest_run[0] < need) begin
        res.status = 1'b1;
      end else begin
        // walk down, left child first when it still fits
        node = 0;
        sz   = SPAN;
        while (sz > need) begin
          if (longest_run[2 * node + 1] >= need) begin
            node = 2 * node + 1;
          end else begin
            node = 2 * node + 2;
          end
          sz = sz >> 1;
        end
        longest_run[node] = '0;
        res.alloc_offset  = OFF_W'((node + 1) * sz - SPAN);
        while (node != 0) begin
          node = (node - 1) / 2;
          lft  = longest_run[2 * node + 1];
          rgt  = longest_run[2 * node + 2];
          longest_run[node] = N_W'(lft > rgt ? lft : rgt);
        end
        pages_left = pages_left - need;
      end
    end else if (need <= SPAN && offs < SPAN) begin
      // climb from the leaf to the node of the freed size
      node = SPAN + offs - 1;
      sz   = 1;
      while (sz < need) begin
        sz   = sz << 1;
        node = (node - 1) / 2;
      end
      longest_run[node] = N_W'(sz);
      while (node != 0) begin
        node = (node - 1) / 2;
        sz   = sz << 1;
        lft  = longest_run[2 * node + 1];
        rgt  = longest_run[2 * node + 2];
        if (lft + rgt == sz) begin
          longest_run[node] = N_W'(sz);
        end else begin
          longest_run[node] = N_W'(lft > rgt ? lft : rgt);
        end
      end
      pages_left = pages_left + need;
      if (pages_left > TOTAL_PAGES) pages_left = TOTAL_PAGES;
    end
    res.pages_free = PF_W'(pages_left);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t got;
    result_word_t want;
    if (!rst_ni) begin
      clear_tree();
      awaited_words.delete();
      error_total  = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // result first: a word accepted at this edge cannot belong to the
      // request accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        got.status       = status_i;
        got.alloc_offset = alloc_offset_i;
        got.pages_free   = pages_free_i;
        if (awaited_words.size() == 0) begin
          $error("unexpected result word: status %0d alloc_offset %0d pages_free %0d",
                 got.status, got.alloc_offset, got.pages_free);
          error_total++;
        end else begin
          want = awaited_words.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_total++;
          end
          if (got.alloc_offset !== want.alloc_offset) begin
            $error("alloc_offset: expected %0d, got %0d", want.alloc_offset,
                   got.alloc_offset);
            error_total++;
          end
          if (got.pages_free !== want.pages_free) begin
            $error("pages_free: expected %0d, got %0d", want.pages_free,
                   got.pages_free);
            error_total++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_words.push_back(apply_request(op_i, page_count_i, block_offset_i));
      end
      mismatches_o <= error_total;
      pending_o    <= awaited_words.size();
    end
  end

endmodule

>>> tb/tb_buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives alloc and free requests into the allocator: a directed opening over
// the corner cases, then mostly well-formed alloc/free traffic with random
// sizes and some malformed frees. Both channels idle at random. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator;
  import bpa_pkg::*;

  localparam int   PAGES        = TOTAL_PAGES_DEF;
  localparam logic OP_ALLOC     = ~OP_FREE;
  localparam int   RANDOM_WORDS = 1750;
  // slowest run: ~1800 words, each with its idle gap, tree walk and output
  // stall, plus the clearing pass after reset; the limit is several times that
  localparam int   CYCLE_LIMIT  = 500_000;
  localparam int   DRAIN_CYCLES = 40;

  // request as sent, kept until its result word comes back
  typedef struct {
    logic             op;
    logic [PC_W-1:0]  count;
    int unsigned      order;  // log2 of the rounded block size
  } request_t;

  // a block the allocator handed out and that is still held
  typedef struct {
    logic [OFF_W-1:0] base;
    logic [PC_W-1:0]  count;
    int unsigned      order;
  } held_block_t;

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             op_i           = OP_ALLOC;
  logic [PC_W-1:0]  page_count_i   = '0;
  logic [OFF_W-1:0] block_offset_i = '0;
  logic             out_stall_i    = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             status_o;
  logic [OFF_W-1:0] alloc_offset_o;
  logic [PF_W-1:0]  pages_free_o;

  int               mismatches;
  int               pending;

  request_t         sent_requests [$];
  held_block_t      held_blocks   [$];
  int unsigned      sent_words = 0;
  int unsigned      got_words  = 0;
  // when set, neither side idles: back to back words on both channels
  bit               steady     = 1'b0;

  buddy_page_allocator #(
    .TOTAL_PAGES(PAGES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .page_count_i  (page_count_i),
    .block_offset_i(block_offset_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .alloc_offset_o(alloc_offset_o),
    .pages_free_o  (pages_free_o)
  );

  bpa_alloc_checker #(
    .TOTAL_PAGES(PAGES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .op_i          (op_i),
    .page_count_i  (page_count_i),
    .block_offset_i(block_offset_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .alloc_offset_i(alloc_offset_o),
    .pages_free_i  (pages_free_o),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sends one request word. Called right after a rising edge and returns
  // right after the edge that accepted the word. Valid is only lowered when
  // a gap is drawn, so a back to back word never toggles it within a step.
  task automatic send_word(input logic op, input int unsigned cnt,
                           input int unsigned offs);
    int unsigned gap;
    request_t    req;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    page_count_i   <= PC_W'(cnt);
    block_offset_i <= OFF_W'(offs);
    do @(posedge clk_i); while (in_stall_o);
    req.op    = op;
    req.count = PC_W'(cnt);
    req.order = 0;
    while ((1 << req.order) < cnt) req.order++;
    sent_requests.push_back(req);
    sent_words++;
  endtask

  // Holds the sender off until every word sent has its result back.
  // Counts are compared on the falling edge, after all updates of the
  // rising edge have settled.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (sent_words != got_words) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Result side: draws a stall length per word, then takes the next word.
  // Successful allocations go on the held list so that later frees can hand
  // back real blocks.
  initial begin : result_sink
    int unsigned hold;
    request_t    req;
    held_block_t blk;
    @(posedge clk_i);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got_words++;
      if (sent_requests.size() > 0) begin
        req = sent_requests.pop_front();
        if (req.op == OP_ALLOC && !status_o) begin
          blk.base  = alloc_offset_o;
          blk.count = req.count;
          blk.order = req.order;
          held_blocks.push_back(blk);
        end
      end
    end
  end

  initial begin : stimulus
    int          n;
    int unsigned pick;
    int unsigned idx;
    int unsigned k;
    int unsigned cnt;
    int unsigned offs;
    held_block_t blk;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block clears its tree after reset with in_stall_o high; the first
    // word simply waits for the handshake

    // --- directed opening ---
    send_word(OP_ALLOC, 1, 0);        // single page at the left edge
    send_word(OP_ALLOC, 0, 0);        // zero count is one page
    send_word(OP_ALLOC, 3, 0);        // rounds to four
    send_word(OP_FREE, 1, 0);
    send_word(OP_FREE, 0, 1);         // zero count free, buddies merge
    send_word(OP_FREE, 4, 6);         // offset inside the block, not aligned
    send_word(OP_ALLOC, PAGES, 0);    // whole area
    send_word(OP_ALLOC, 1, 0);        // fails, counter at zero
    send_word(OP_FREE, PAGES, 0);     // whole area back at once
    send_word(OP_FREE, 2047, 0);      // larger than the area: ignored
    send_word(OP_FREE, 1025, 5);      // also ignored
    send_word(OP_FREE, 1, 1023);      // counter clamps at the area size
    send_word(OP_ALLOC, 2047, 1023);  // rounds to 2048, fails
    send_word(OP_ALLOC, 1025, 0);     // fails
    send_word(OP_ALLOC, 512, 0);
    send_word(OP_ALLOC, 600, 0);      // rounds to 1024, fails
    send_word(OP_ALLOC, 1, 0);        // single page from the right half
    send_word(OP_FREE, 512, 512);
    send_word(OP_FREE, 300, 0);       // rounds to 512
    send_word(OP_ALLOC, 1, 1023);     // offset field ignored on alloc
    send_word(OP_FREE, 1, 1023);      // bogus free bumps counter to full
    send_word(OP_ALLOC, PAGES, 0);    // counter allows it, root does not
    send_word(OP_FREE, 1, 0);
    send_word(OP_ALLOC, 2, 0);
    send_word(OP_FREE, 2, 1);         // unaligned free of a pair
    wait_all_results();

    // --- random traffic ---
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n % 500 == 499) wait_all_results();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // noise alloc, oversized counts included
        send_word(OP_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (pick < 8) begin
        // noise free: any count, any offset, often a double free
        send_word(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (held_blocks.size() == 0 ||
                   pick < (held_blocks.size() < 24 ? 62 : 40)) begin
        // mostly small blocks, a few up to the whole area
        pick = $urandom_range(0, 99);
        k    = (pick < 60) ? $urandom_range(0, 3) :
               (pick < 92) ? $urandom_range(4, 7) : $urandom_range(8, 10);
        cnt  = (k == 0) ? $urandom_range(0, 1) :
               $urandom_range((1 << (k - 1)) + 1, 1 << k);
        send_word(OP_ALLOC, cnt, $urandom_range(0, 1023));
      end else begin
        // hand back a held block, sometimes by an offset inside it
        idx  = $urandom_range(0, held_blocks.size() - 1);
        blk  = held_blocks[idx];
        held_blocks.delete(idx);
        offs = blk.base;
        if ($urandom_range(0, 3) == 0) offs = blk.base + $urandom_range(0, (1 << blk.order) - 1);
        send_word(OP_FREE, blk.count, offs);
      end
    end

    // --- drain and verdict ---
    steady = 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_buddy_page_allocator passed");
    end else begin
      $display("tb_buddy_page_allocator failed");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_buddy_page_allocator failed");
    $finish;
  end

endmodule
